>>> src/bph_pkg.sv
// Shared types and constants for the binary min-heap priority queue.
// Used by the channel interfaces, the heap memory, the sequencer and the top level.
// Depends on nothing.
package bph_pkg;

    localparam int HEAP_DEPTH = 64;
    localparam int PRI_W      = 16;
    localparam int DATA_W     = 16;
    localparam int IDX_W      = $clog2(HEAP_DEPTH);
    localparam int COUNT_W    = IDX_W;
    localparam int STATUS_W   = 2;

    // One slot is always left unused (slot 0), so capacity is depth minus one.
    localparam logic [COUNT_W-1:0] CAPACITY = COUNT_W'(HEAP_DEPTH - 1);

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_DEL_LOAD,
        ST_DEL_RD,
        ST_DEL_PICK,
        ST_DEL_CMP,
        ST_DONE
    } state_t;

    typedef struct packed
    {
        logic [PRI_W-1:0]  pri;
        logic [DATA_W-1:0] data;
    } slot_t;

    typedef struct packed
    {
        logic              req_type;
        logic [PRI_W-1:0]  entry_priority;
        logic [DATA_W-1:0] entry_data;
    } req_t;

    typedef struct packed
    {
        logic [DATA_W-1:0]  out_data;
        logic [PRI_W-1:0]   out_priority;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0] entry_count;
        logic               is_empty;
    } rsl_t;

    typedef struct packed
    {
        logic             we;
        logic [IDX_W-1:0] waddr;
        slot_t            wdata;
        logic [IDX_W-1:0] raddr_a;
        logic [IDX_W-1:0] raddr_b;
    } mem_req_t;

endpackage

>>> src/bph_req_if.sv
// Request channel of the heap queue: valid/ready handshake and the request item.
// Depends on bph_pkg.
interface bph_req_if;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [bph_pkg::PRI_W-1:0]  entry_priority;
    logic [bph_pkg::DATA_W-1:0] entry_data;

    modport source (output valid, output req_type, output entry_priority,
                    output entry_data, input ready);
    modport sink   (input valid, input req_type, input entry_priority,
                    input entry_data, output ready);
endinterface

>>> src/bph_rsp_if.sv
// Result channel of the heap queue: valid/ready handshake and the result item.
// Depends on bph_pkg.
interface bph_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [bph_pkg::DATA_W-1:0]   out_data;
    logic [bph_pkg::PRI_W-1:0]    out_priority;
    logic [bph_pkg::STATUS_W-1:0] status;
    logic [bph_pkg::COUNT_W-1:0]  entry_count;
    logic                        is_empty;

    modport source (output valid, output out_data, output out_priority,
                    output status, output entry_count, output is_empty, input ready);
    modport sink   (input valid, input out_data, input out_priority,
                    input status, input entry_count, input is_empty, output ready);
endinterface

>>> src/bph_mem.sv
// Heap slot memory: one write port and two read ports with registered read data.
// Depends on bph_pkg.
module bph_mem
(
    input  logic              clk,
    input  bph_pkg::mem_req_t mreq,
    output bph_pkg::slot_t    rd_a,
    output bph_pkg::slot_t    rd_b
);

    bph_pkg::slot_t mem [bph_pkg::HEAP_DEPTH];
    bph_pkg::slot_t rd_a_reg;
    bph_pkg::slot_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (mreq.we)
        begin
            mem[mreq.waddr] <= mreq.wdata;
        end
        rd_a_reg <= mem[mreq.raddr_a];
        rd_b_reg <= mem[mreq.raddr_b];
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

>>> src/bph_ctrl.sv
// Sequencer of the heap queue: sifts entries up and down one level at a time
// with a single shared priority comparator. Depends on bph_pkg; drives bph_mem.
module bph_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bph_pkg::req_t     in_item,
    output logic              res_valid,
    output bph_pkg::rsl_t     res,
    input  logic              res_take,
    output bph_pkg::mem_req_t mreq,
    input  bph_pkg::slot_t    rd_a,
    input  bph_pkg::slot_t    rd_b
);

    bph_pkg::state_t                   state_reg, state_next;
    logic [bph_pkg::COUNT_W-1:0]       count_reg, count_next;
    logic [bph_pkg::IDX_W-1:0]         idx_reg, idx_next;
    logic [bph_pkg::IDX_W-1:0]         child_idx_reg, child_idx_next;
    bph_pkg::slot_t                    ne_reg, ne_next;
    bph_pkg::slot_t                    last_reg, last_next;
    bph_pkg::slot_t                    child_reg, child_next;
    logic [bph_pkg::DATA_W-1:0]        res_data_reg, res_data_next;
    logic [bph_pkg::PRI_W-1:0]         res_pri_reg, res_pri_next;
    bph_pkg::status_t                  status_reg, status_next;

    logic [bph_pkg::PRI_W-1:0]         cmp_a;
    logic [bph_pkg::PRI_W-1:0]         cmp_b;
    logic                              cmp_lt;
    logic [bph_pkg::IDX_W:0]           left;
    logic [bph_pkg::IDX_W-1:0]         right;
    logic                              accept;

    // Left child index is one bit wider so that running off the array shows up.
    assign left   = {idx_reg, 1'b0};
    assign right  = {left[bph_pkg::IDX_W-1:1], 1'b1};
    assign accept = in_valid && in_ready;
    assign cmp_lt = cmp_a < cmp_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bph_pkg::ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        child_idx_reg <= child_idx_next;
        ne_reg        <= ne_next;
        last_reg      <= last_next;
        child_reg     <= child_next;
        res_data_reg  <= res_data_next;
        res_pri_reg   <= res_pri_next;
        status_reg    <= status_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        child_idx_next = child_idx_reg;
        ne_next        = ne_reg;
        last_next      = last_reg;
        child_next     = child_reg;
        res_data_next  = res_data_reg;
        res_pri_next   = res_pri_reg;
        status_next    = status_reg;
        in_ready       = 1'b0;
        res_valid      = 1'b0;
        cmp_a          = '0;
        cmp_b          = '0;
        mreq.we        = 1'b0;
        mreq.waddr     = idx_reg;
        mreq.wdata     = last_reg;
        mreq.raddr_a   = idx_reg;
        mreq.raddr_b   = idx_reg;

        unique case (state_reg)
            bph_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                // Root and last slot are fetched speculatively for a delete.
                mreq.raddr_a = bph_pkg::IDX_W'(1);
                mreq.raddr_b = count_reg;
                if (accept)
                begin
                    res_data_next = '0;
                    res_pri_next  = '0;
                    status_next   = bph_pkg::STAT_DONE;
                    if (in_item.req_type == bph_pkg::OP_INSERT)
                    begin
                        if (count_reg >= bph_pkg::CAPACITY)
                        begin
                            status_next = bph_pkg::STAT_FULL;
                            state_next  = bph_pkg::ST_DONE;
                        end
                        else
                        begin
                            ne_next.pri  = in_item.entry_priority;
                            ne_next.data = in_item.entry_data;
                            idx_next     = count_reg + bph_pkg::IDX_W'(1);
                            state_next   = bph_pkg::ST_INS_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = bph_pkg::STAT_EMPTY;
                            state_next  = bph_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = bph_pkg::ST_DEL_LOAD;
                        end
                    end
                end
            end

            bph_pkg::ST_INS_RD:
            begin
                if (idx_reg == bph_pkg::IDX_W'(1))
                begin
                    mreq.we    = 1'b1;
                    mreq.wdata = ne_reg;
                    count_next = count_reg + bph_pkg::COUNT_W'(1);
                    state_next = bph_pkg::ST_DONE;
                end
                else
                begin
                    mreq.raddr_a = idx_reg >> 1;
                    state_next   = bph_pkg::ST_INS_CMP;
                end
            end

            bph_pkg::ST_INS_CMP:
            begin
                cmp_a   = ne_reg.pri;
                cmp_b   = rd_a.pri;
                mreq.we = 1'b1;
                if (cmp_lt)
                begin
                    mreq.wdata = rd_a;
                    idx_next   = idx_reg >> 1;
                    state_next = bph_pkg::ST_INS_RD;
                end
                else
                begin
                    mreq.wdata = ne_reg;
                    count_next = count_reg + bph_pkg::COUNT_W'(1);
                    state_next = bph_pkg::ST_DONE;
                end
            end

            bph_pkg::ST_DEL_LOAD:
            begin
                res_data_next = rd_a.data;
                res_pri_next  = rd_a.pri;
                last_next     = rd_b;
                idx_next      = bph_pkg::IDX_W'(1);
                state_next    = bph_pkg::ST_DEL_RD;
            end

            bph_pkg::ST_DEL_RD:
            begin
                // The count still includes the last entry while sifting down.
                if (left > {1'b0, count_reg} || left[bph_pkg::IDX_W])
                begin
                    mreq.we    = 1'b1;
                    mreq.wdata = last_reg;
                    count_next = count_reg - bph_pkg::COUNT_W'(1);
                    state_next = bph_pkg::ST_DONE;
                end
                else
                begin
                    mreq.raddr_a = left[bph_pkg::IDX_W-1:0];
                    mreq.raddr_b = right;
                    state_next   = bph_pkg::ST_DEL_PICK;
                end
            end

            bph_pkg::ST_DEL_PICK:
            begin
                // The right child wins only when it exists and is strictly smaller.
                cmp_a = rd_b.pri;
                cmp_b = rd_a.pri;
                if (left != {1'b0, count_reg} && cmp_lt)
                begin
                    child_next     = rd_b;
                    child_idx_next = right;
                end
                else
                begin
                    child_next     = rd_a;
                    child_idx_next = left[bph_pkg::IDX_W-1:0];
                end
                state_next = bph_pkg::ST_DEL_CMP;
            end

            bph_pkg::ST_DEL_CMP:
            begin
                cmp_a   = child_reg.pri;
                cmp_b   = last_reg.pri;
                mreq.we = 1'b1;
                if (cmp_lt)
                begin
                    mreq.wdata = child_reg;
                    idx_next   = child_idx_reg;
                    state_next = bph_pkg::ST_DEL_RD;
                end
                else
                begin
                    mreq.wdata = last_reg;
                    count_next = count_reg - bph_pkg::COUNT_W'(1);
                    state_next = bph_pkg::ST_DONE;
                end
            end

            bph_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = bph_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bph_pkg::ST_IDLE;
            end
        endcase
    end

    assign res.out_data     = res_data_reg;
    assign res.out_priority = res_pri_reg;
    assign res.status       = status_reg;
    assign res.entry_count  = count_reg;
    assign res.is_empty     = (count_reg == '0);

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bph_pkg::CAPACITY)
        else $error("entry count above capacity");

    a_no_slot0: assert property (@(posedge clk) disable iff (!rst_n)
        mreq.we |-> mreq.waddr != '0)
        else $error("write to unused slot zero");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bph_pkg::ST_DONE && status_reg == bph_pkg::STAT_FULL)
        |-> count_reg == bph_pkg::CAPACITY)
        else $error("full status with room left");

    a_child_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bph_pkg::ST_DEL_CMP
        |-> (child_idx_reg <= count_reg && child_idx_reg != '0))
        else $error("chosen child outside stored entries");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != bph_pkg::ST_DONE && state_next == bph_pkg::ST_DONE
         && status_next == bph_pkg::STAT_DONE)
        |=> count_reg != $past(count_reg))
        else $error("completed operation left count unchanged");
`endif

endmodule

>>> src/binary_min_heap_priority_queue.sv
// Top level of the binary min-heap priority queue: channel ports, result register,
// heap memory and sequencer. Depends on bph_pkg, bph_req_if, bph_rsp_if,
// bph_mem and bph_ctrl.
//
//   Channel  Direction  Contents
//   req      in         req_type, entry_priority, entry_data
//   rsp      out        out_data, out_priority, status, entry_count, is_empty
//
// An insert reads and compares one parent per level as it climbs; a delete reads both children,
// picks the smaller and compares it per level as it descends; both are paced by the registered
// memory read and the single shared priority comparator.
// Reset clears the count, so the heap is empty at once; slot contents are not cleared.
// A result waits in the output register; a new item is taken meanwhile, and the
// sequencer holds its finished result only while that register is still occupied.
module binary_min_heap_priority_queue
(
    input logic        clk,
    input logic        rst_n,
    bph_req_if.sink    req,
    bph_rsp_if.source  rsp
);

    bph_pkg::req_t     in_item;
    bph_pkg::rsl_t     res;
    bph_pkg::rsl_t     out_reg;
    bph_pkg::mem_req_t mreq;
    bph_pkg::slot_t    rd_a;
    bph_pkg::slot_t    rd_b;
    logic              res_valid;
    logic              res_take;
    logic              out_valid_reg;

    assign in_item.req_type       = req.req_type;
    assign in_item.entry_priority = req.entry_priority;
    assign in_item.entry_data     = req.entry_data;

    assign res_take = res_valid && (!out_valid_reg || rsp.ready);

    bph_mem u_mem
    (
        .clk  (clk),
        .mreq (mreq),
        .rd_a (rd_a),
        .rd_b (rd_b)
    );

    bph_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take),
        .mreq      (mreq),
        .rd_a      (rd_a),
        .rd_b      (rd_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.out_data     = out_reg.out_data;
    assign rsp.out_priority = out_reg.out_priority;
    assign rsp.status       = out_reg.status;
    assign rsp.entry_count  = out_reg.entry_count;
    assign rsp.is_empty     = out_reg.is_empty;

endmodule

>>> tb/tb.sv
// Self-checking testbench for binary_min_heap_priority_queue: a directed table, then
// fill/drain traffic with random contents, checked against known results or a heap mirror.
// Depends on bph_pkg, bph_req_if, bph_rsp_if and the heap queue RTL.
module tb;

    typedef enum
    {
        LOAD_FILL,
        LOAD_DRAIN,
        LOAD_MIX
    } load_t;

    typedef struct packed
    {
        bph_pkg::op_t                op;
        logic [bph_pkg::PRI_W-1:0]   pri;
        logic [bph_pkg::DATA_W-1:0]  data;
        logic                        known;
        bph_pkg::rsl_t               want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    bph_req_if req_ch ();
    bph_rsp_if rsp_ch ();

    binary_min_heap_priority_queue i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Mirror of the heap contents and its fill level.
    bph_pkg::slot_t heap_mirror [bph_pkg::HEAP_DEPTH];
    int unsigned    heap_fill = 0;

    bph_pkg::rsl_t results_due [$];
    int            fail_count  = 0;
    int            tx_idle_pct = 37;
    int            rx_idle_pct = 51;

    // Rows whose result is obvious carry it; the rest are checked against the mirror.
    dir_row_t dir_tab [23] = '{
        '{bph_pkg::OP_DELETE, 16'hFFFF, 16'hFFFF, 1'b1,
          '{16'h0000, 16'h0000, bph_pkg::STAT_EMPTY, 6'd0, 1'b1}},
        '{bph_pkg::OP_INSERT, 16'hFFFF, 16'h0000, 1'b1,
          '{16'h0000, 16'h0000, bph_pkg::STAT_DONE, 6'd1, 1'b0}},
        '{bph_pkg::OP_INSERT, 16'h0000, 16'hFFFF, 1'b1,
          '{16'h0000, 16'h0000, bph_pkg::STAT_DONE, 6'd2, 1'b0}},
        '{bph_pkg::OP_DELETE, 16'h0000, 16'h0000, 1'b1,
          '{16'hFFFF, 16'h0000, bph_pkg::STAT_DONE, 6'd1, 1'b0}},
        '{bph_pkg::OP_DELETE, 16'hFFFF, 16'hFFFF, 1'b1,
          '{16'h0000, 16'hFFFF, bph_pkg::STAT_DONE, 6'd0, 1'b1}},
        '{bph_pkg::OP_DELETE, 16'h5555, 16'hAAAA, 1'b1,
          '{16'h0000, 16'h0000, bph_pkg::STAT_EMPTY, 6'd0, 1'b1}},
        '{bph_pkg::OP_INSERT, 16'h0005, 16'h0001, 1'b0, '0},
        '{bph_pkg::OP_INSERT, 16'h0005, 16'h0002, 1'b0, '0},
        '{bph_pkg::OP_INSERT, 16'h0005, 16'h0003, 1'b0, '0},
        '{bph_pkg::OP_INSERT, 16'h0003, 16'h0004, 1'b0, '0},
        '{bph_pkg::OP_INSERT, 16'h0005, 16'h0005, 1'b0, '0},
        '{bph_pkg::OP_INSERT, 16'hAAAA, 16'h5555, 1'b0, '0},
        '{bph_pkg::OP_INSERT, 16'h5555, 16'hAAAA, 1'b0, '0},
        '{bph_pkg::OP_INSERT, 16'h0005, 16'h0006, 1'b0, '0},
        '{bph_pkg::OP_DELETE, 16'h0000, 16'h0000, 1'b0, '0},
        '{bph_pkg::OP_DELETE, 16'h0000, 16'h0000, 1'b0, '0},
        '{bph_pkg::OP_DELETE, 16'h0000, 16'h0000, 1'b0, '0},
        '{bph_pkg::OP_DELETE, 16'h0000, 16'h0000, 1'b0, '0},
        '{bph_pkg::OP_DELETE, 16'h0000, 16'h0000, 1'b0, '0},
        '{bph_pkg::OP_DELETE, 16'h0000, 16'h0000, 1'b0, '0},
        '{bph_pkg::OP_DELETE, 16'h0000, 16'h0000, 1'b0, '0},
        '{bph_pkg::OP_DELETE, 16'h0000, 16'h0000, 1'b0, '0},
        '{bph_pkg::OP_DELETE, 16'hFFFF, 16'hFFFF, 1'b1,
          '{16'h0000, 16'h0000, bph_pkg::STAT_EMPTY, 6'd0, 1'b1}}
    };

    // Applies one request to the mirror and returns the result it should produce.
    function automatic bph_pkg::rsl_t heap_apply(input bph_pkg::op_t op,
                                                 input logic [bph_pkg::PRI_W-1:0] pri,
                                                 input logic [bph_pkg::DATA_W-1:0] data);
        bph_pkg::rsl_t  res;
        bph_pkg::slot_t moving;
        int unsigned    pos;
        int unsigned    kid;
        res = '0;
        if (op == bph_pkg::OP_INSERT)
        begin
            if (heap_fill >= bph_pkg::HEAP_DEPTH - 1)
            begin
                res.status = bph_pkg::STAT_FULL;
            end
            else
            begin
                moving.pri  = pri;
                moving.data = data;
                pos = heap_fill + 1;
                // Stops below a parent of equal priority, so a new entry never passes an equal one.
                while (pos != 1 && pri < heap_mirror[pos / 2].pri)
                begin
                    heap_mirror[pos] = heap_mirror[pos / 2];
                    pos = pos / 2;
                end
                heap_mirror[pos] = moving;
                heap_fill++;
            end
        end
        else
        begin
            if (heap_fill == 0)
            begin
                res.status = bph_pkg::STAT_EMPTY;
            end
            else
            begin
                moving           = heap_mirror[heap_fill];
                res.out_data     = heap_mirror[1].data;
                res.out_priority = heap_mirror[1].pri;
                pos = 1;
                while (2 * pos <= heap_fill && 2 * pos < bph_pkg::HEAP_DEPTH)
                begin
                    kid = 2 * pos;
                    // The left child wins a tie.
                    if (kid < heap_fill && kid + 1 < bph_pkg::HEAP_DEPTH
                        && heap_mirror[kid].pri > heap_mirror[kid + 1].pri)
                        kid = kid + 1;
                    if (moving.pri <= heap_mirror[kid].pri)
                        break;
                    heap_mirror[pos] = heap_mirror[kid];
                    pos = kid;
                end
                heap_mirror[pos] = moving;
                heap_fill--;
            end
        end
        res.entry_count = heap_fill[bph_pkg::COUNT_W-1:0];
        res.is_empty    = (heap_fill == 0);
        return res;
    endfunction

    task automatic send_req(input bph_pkg::op_t op, input logic [bph_pkg::PRI_W-1:0] pri,
                            input logic [bph_pkg::DATA_W-1:0] data, input logic known,
                            input bph_pkg::rsl_t want);
        bph_pkg::rsl_t predicted;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.req_type       <= op;
        req_ch.entry_priority <= pri;
        req_ch.entry_data     <= data;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        predicted = heap_apply(op, pri, data);
        results_due.push_back(known ? want : predicted);
    endtask

    task automatic check_field(input string name, input logic [31:0] expv,
                               input logic [31:0] actv);
        if (actv !== expv)
        begin
            $error("%s: expected %0h, got %0h", name, expv, actv);
            fail_count++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("tb failed");
        $finish;
    end

    // Result side: random back-pressure and in-order comparison.
    initial
    begin
        bph_pkg::rsl_t want;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result arrived with no item outstanding");
                    fail_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("out_data", 32'(want.out_data), 32'(rsp_ch.out_data));
                    check_field("out_priority", 32'(want.out_priority),
                                32'(rsp_ch.out_priority));
                    check_field("status", 32'(want.status), 32'(rsp_ch.status));
                    check_field("entry_count", 32'(want.entry_count),
                                32'(rsp_ch.entry_count));
                    check_field("is_empty", 32'(want.is_empty), 32'(rsp_ch.is_empty));
                end
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial
    begin
        load_t                      load_mode;
        bph_pkg::op_t               op;
        logic [bph_pkg::PRI_W-1:0]  pri;
        logic [bph_pkg::DATA_W-1:0] data;
        int                         pick;
        rst_n                 <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.req_type       <= bph_pkg::OP_INSERT;
        req_ch.entry_priority <= '0;
        req_ch.entry_data     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_req(dir_tab[i].op, dir_tab[i].pri, dir_tab[i].data, dir_tab[i].known,
                     dir_tab[i].want);

        load_mode = LOAD_FILL;
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 51 : 0;
            rx_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 37 : 0;
            repeat (350)
            begin
                // Run the heap up to full and down to empty, lingering at both ends
                // so that refused inserts and refused deletes both occur.
                if (heap_fill == bph_pkg::HEAP_DEPTH - 1 && $urandom_range(0, 2) == 0)
                    load_mode = LOAD_DRAIN;
                else if (heap_fill == 0 && $urandom_range(0, 2) == 0)
                    load_mode = ($urandom_range(0, 3) == 0) ? LOAD_MIX : LOAD_FILL;
                pick = int'($urandom_range(0, 99));
                case (load_mode)
                    LOAD_FILL:  op = (pick < 85) ? bph_pkg::OP_INSERT : bph_pkg::OP_DELETE;
                    LOAD_DRAIN: op = (pick < 15) ? bph_pkg::OP_INSERT : bph_pkg::OP_DELETE;
                    default:    op = (pick < 50) ? bph_pkg::OP_INSERT : bph_pkg::OP_DELETE;
                endcase
                // Small priorities give plenty of ties; extremes come up now and then.
                pick = int'($urandom_range(0, 9));
                if (pick < 4)
                    pri = bph_pkg::PRI_W'($urandom_range(0, 7));
                else if (pick == 4)
                    pri = $urandom_range(0, 1) ? '1 : '0;
                else
                    pri = bph_pkg::PRI_W'($urandom);
                data = bph_pkg::DATA_W'($urandom);
                send_req(op, pri, data, 1'b0, '0);
            end
        end
        req_ch.valid <= 1'b0;

        while (results_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

>>> binary_min_heap_priority_queue.f
src/bph_pkg.sv
src/bph_req_if.sv
src/bph_rsp_if.sv
src/bph_mem.sv
src/bph_ctrl.sv
src/binary_min_heap_priority_queue.sv
tb/tb.sv
